// ===== sv/mau_pkg.sv =====
// shared types and constants for the modular arithmetic unit
// no dependencies; compiled first
package mau_pkg;

    localparam int OPCODE_WIDTH = 3;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_POW = 3'd3,
        OP_INV = 3'd4,
        OP_DIV = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SELECT,
        S_POW_STEP,
        S_POW_WAIT,
        S_MUL_WAIT,
        S_FINISH
    } state_t;

endpackage

// ===== sv/mau_if.sv =====
// valid/ready channel interfaces for request and response of the unit
// depends on mau_pkg
interface mau_in_if #(
    parameter int VALUE_WIDTH = 31,
    parameter int EXP_WIDTH   = 63
);
    import mau_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OPCODE_WIDTH-1:0] opcode;
    logic [VALUE_WIDTH-1:0]  operand_a;
    logic [VALUE_WIDTH-1:0]  operand_b;
    logic [EXP_WIDTH-1:0]    exponent;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    output exponent, input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    input exponent, output ready);
endinterface

interface mau_out_if #(
    parameter int VALUE_WIDTH = 31
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ===== sv/mau_reduce.sv =====
// bit-serial remainder: value mod modulus, one value bit per cycle, msb first
// no package dependencies
module mau_reduce #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [VALUE_WIDTH-1:0] modulus,
    output logic                   busy,
    output logic [VALUE_WIDTH-1:0] rem
);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH:0]   trial;

    always_comb
    begin
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg, shift_reg[VALUE_WIDTH-1]};
        if (trial >= {1'b0, modulus})
        begin
            trial = trial - {1'b0, modulus};
        end
        if (start)
        begin
            cnt_next   = CW'(VALUE_WIDTH);
            shift_next = value;
            rem_next   = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next   = cnt_reg - CW'(1);
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            rem_next   = trial[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;
endmodule

// ===== sv/mau_mulser.sv =====
// bit-serial modular multiplier, msb first over y: double, then add x
// each y bit has a doubling phase and an adding phase; inputs must already lie below the modulus
module mau_mulser #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] x,
    input  logic [VALUE_WIDTH-1:0] y,
    input  logic [VALUE_WIDTH-1:0] modulus,
    output logic                   busy,
    output logic [VALUE_WIDTH-1:0] prod
);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] x_reg, x_next;
    logic [VALUE_WIDTH-1:0] y_reg, y_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH:0]   t;

    always_comb
    begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        // phase 0 doubles, phase 1 adds x when the current y bit is set
        if (!phase_reg)
        begin
            t = {acc_reg, 1'b0};
        end
        else if (y_reg[VALUE_WIDTH-1])
        begin
            t = {1'b0, acc_reg} + {1'b0, x_reg};
        end
        else
        begin
            t = {1'b0, acc_reg};
        end
        if (t >= {1'b0, modulus})
        begin
            t = t - {1'b0, modulus};
        end
        if (start)
        begin
            cnt_next   = CW'(VALUE_WIDTH);
            phase_next = 1'b0;
            x_next     = x;
            y_next     = y;
            acc_next   = '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_next   = t[VALUE_WIDTH-1:0];
            phase_next = !phase_reg;
            if (phase_reg)
            begin
                y_next   = {y_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;
endmodule

// ===== sv/modular_arithmetic_unit.sv =====
// top level of the modular arithmetic unit: control sequencer, modulus register
// depends on mau_pkg, mau_if, mau_reduce and mau_mulser
//
// One request at a time. Both operands are first reduced by bit-serial
// remainder units; add and subtract then finish. Multiply runs the
// bit-serial multiplier. Power steps through the exponent bits up to the
// highest set one; square and multiply of each step run on two multipliers
// side by side. Inverse is a power with exponent modulus-2, divide adds one
// multiply after it. A new request is taken while the previous result waits
// in the output register. The user must see that the modulus is written only
// while the unit is idle; the unit does not enforce it. A modulus below two
// makes every result zero.
module modular_arithmetic_unit #(
    parameter int VALUE_WIDTH = 31,
    parameter int EXP_WIDTH   = 63
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   modulus_we,
    input  logic [VALUE_WIDTH-1:0] modulus_wdata,
    mau_in_if.sink                 request,
    mau_out_if.source              response
);
    import mau_pkg::*;

    localparam int XW = (EXP_WIDTH > VALUE_WIDTH) ? EXP_WIDTH : VALUE_WIDTH;
    localparam logic [63:0] MOD_RESET_FULL = 64'd1000000007;

    state_t                 state_reg, state_next;
    opcode_t                op_reg, op_next;
    logic [XW-1:0]          exp_reg, exp_next;
    logic [VALUE_WIDTH-1:0] base_reg, base_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_result_reg, out_result_next;
    logic [VALUE_WIDTH-1:0] modulus_reg;

    logic                   red_start;
    logic                   red_a_busy, red_b_busy;
    logic [VALUE_WIDTH-1:0] red_a, red_b;
    logic                   mul_a_start, mul_b_start;
    logic                   mul_a_busy, mul_b_busy;
    logic [VALUE_WIDTH-1:0] mul_a_x, mul_a_y;
    logic [VALUE_WIDTH-1:0] mul_a_prod, mul_b_prod;
    logic [VALUE_WIDTH:0]   sum, diff;

    mau_reduce #(.VALUE_WIDTH(VALUE_WIDTH)) u_reduce_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .value   (request.operand_a),
        .modulus (modulus_reg),
        .busy    (red_a_busy),
        .rem     (red_a)
    );

    mau_reduce #(.VALUE_WIDTH(VALUE_WIDTH)) u_reduce_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .value   (request.operand_b),
        .modulus (modulus_reg),
        .busy    (red_b_busy),
        .rem     (red_b)
    );

    mau_mulser #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_a_start),
        .x       (mul_a_x),
        .y       (mul_a_y),
        .modulus (modulus_reg),
        .busy    (mul_a_busy),
        .prod    (mul_a_prod)
    );

    // squaring unit of the power loop
    mau_mulser #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_b_start),
        .x       (base_reg),
        .y       (base_reg),
        .modulus (modulus_reg),
        .busy    (mul_b_busy),
        .prod    (mul_b_prod)
    );

    assign request.ready   = (state_reg == S_IDLE);
    assign response.valid  = out_valid_reg;
    assign response.result = out_result_reg;

    assign sum  = {1'b0, red_a} + {1'b0, red_b};
    assign diff = {1'b0, red_a} + {1'b0, modulus_reg} - {1'b0, red_b};

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        exp_next        = exp_reg;
        base_next       = base_reg;
        acc_next        = acc_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        red_start       = 1'b0;
        mul_a_start     = 1'b0;
        mul_b_start     = 1'b0;
        mul_a_x         = red_a;
        mul_a_y         = red_b;

        if (response.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    op_next  = opcode_t'(request.opcode);
                    exp_next = XW'(request.exponent);
                    if (modulus_reg < VALUE_WIDTH'(2))
                    begin
                        res_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        red_start  = 1'b1;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (!red_a_busy && !red_b_busy)
                begin
                    state_next = S_SELECT;
                end
            end
            S_SELECT:
            begin
                acc_next = VALUE_WIDTH'(1);
                case (op_reg)
                    OP_ADD:
                    begin
                        if (sum >= {1'b0, modulus_reg})
                        begin
                            res_next = VALUE_WIDTH'(sum - {1'b0, modulus_reg});
                        end
                        else
                        begin
                            res_next = sum[VALUE_WIDTH-1:0];
                        end
                        state_next = S_FINISH;
                    end
                    OP_SUB:
                    begin
                        if (red_a >= red_b)
                        begin
                            res_next = red_a - red_b;
                        end
                        else
                        begin
                            res_next = diff[VALUE_WIDTH-1:0];
                        end
                        state_next = S_FINISH;
                    end
                    OP_MUL:
                    begin
                        mul_a_start = 1'b1;
                        state_next  = S_MUL_WAIT;
                    end
                    OP_POW:
                    begin
                        base_next  = red_a;
                        state_next = S_POW_STEP;
                    end
                    OP_INV:
                    begin
                        if (red_a == '0)
                        begin
                            res_next   = '0;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            base_next  = red_a;
                            exp_next   = XW'(modulus_reg - VALUE_WIDTH'(2));
                            state_next = S_POW_STEP;
                        end
                    end
                    OP_DIV:
                    begin
                        if (red_b == '0)
                        begin
                            res_next   = '0;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            base_next  = red_b;
                            exp_next   = XW'(modulus_reg - VALUE_WIDTH'(2));
                            state_next = S_POW_STEP;
                        end
                    end
                    default:
                    begin
                        res_next   = '0;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_POW_STEP:
            begin
                mul_a_x = acc_reg;
                mul_a_y = base_reg;
                if (exp_reg == '0)
                begin
                    if (op_reg == OP_DIV)
                    begin
                        // a times the inverse of b
                        mul_a_x     = red_a;
                        mul_a_y     = acc_reg;
                        mul_a_start = 1'b1;
                        state_next  = S_MUL_WAIT;
                    end
                    else
                    begin
                        res_next   = acc_reg;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    mul_a_start = 1'b1;
                    mul_b_start = 1'b1;
                    state_next  = S_POW_WAIT;
                end
            end
            S_POW_WAIT:
            begin
                if (!mul_a_busy && !mul_b_busy)
                begin
                    if (exp_reg[0])
                    begin
                        acc_next = mul_a_prod;
                    end
                    base_next  = mul_b_prod;
                    exp_next   = exp_reg >> 1;
                    state_next = S_POW_STEP;
                end
            end
            S_MUL_WAIT:
            begin
                if (!mul_a_busy)
                begin
                    res_next   = mul_a_prod;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // output slot is free or being emptied by this transfer
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = res_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MOD_RESET_FULL[VALUE_WIDTH-1:0];
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        exp_reg        <= exp_next;
        base_reg       <= base_next;
        acc_reg        <= acc_next;
        res_reg        <= res_next;
        out_result_reg <= out_result_next;
    end
endmodule
